[design/rk4s_pkg.sv]
package rk4s_pkg;

   // Fixed-point format and field widths.
   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int STEP_W    = 31;
   localparam int COUNT_W   = 16;
   localparam int CSR_IDX_W = 1;

   // The shared multiplier takes one extra bit so that unsigned 32-bit
   // operands of the constant divisions fit as positive signed values.
   localparam int MUL_W  = DATA_W + 1;
   localparam int PROD_W = 2 * MUL_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int ACC_W  = DATA_W + 3;
   localparam int STAGE_W = 2;

   typedef logic signed [DATA_W-1:0]  fix_type;
   typedef logic signed [MUL_W-1:0]   mul_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic signed [ACC_W-1:0]   acc_type;
   typedef logic [STEP_W-1:0]         step_type;
   typedef logic [COUNT_W-1:0]        count_type;
   typedef logic [STAGE_W-1:0]        stage_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_SIZE,
      CSR_END_X
   } csr_index_type;

   // Reset values of the configuration registers: h = 0.1, end = 0.5.
   localparam step_type STEP_SIZE_RESET = STEP_W'(6554);
   localparam fix_type  END_X_RESET     = DATA_W'(32768);

   // Runge-Kutta stage numbers.
   localparam stage_type STG_1 = 2'd0;
   localparam stage_type STG_2 = 2'd1;
   localparam stage_type STG_3 = 2'd2;
   localparam stage_type STG_4 = 2'd3;

   // Rounded division by 3 and 6 through a reciprocal: for n below 2^32,
   // floor(n/3) = (n * RECIP3) >> 33 and floor(n/6) = (n * RECIP3) >> 34.
   localparam logic [DATA_W-1:0] RECIP3     = 32'hAAAA_AAAB;
   localparam int                DIV3_SHIFT = DATA_W + 1;
   localparam int                DIV6_SHIFT = DATA_W + 2;
   localparam logic [DATA_W-1:0] DIV3_BIAS  = DATA_W'(1);
   localparam logic [DATA_W-1:0] DIV6_BIAS  = DATA_W'(3);

   localparam fix_type FIX_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
   localparam fix_type FIX_MIN = {1'b1, {(DATA_W - 1){1'b0}}};
   localparam sum_type SUM_FIX_MAX = sum_type'(FIX_MAX);
   localparam sum_type SUM_FIX_MIN = sum_type'(FIX_MIN);
   localparam sum_type ROUND_HALF  = sum_type'(1) <<< (FRAC_BITS - 1);

   typedef struct packed {
      fix_type val;
      logic    ovf;
   } sat_type;

   // Clamp a wide signed value to the fixed-point range and flag the clamp.
   function automatic sat_type sat_fix(input sum_type v);
      sat_type r;
      if (v > SUM_FIX_MAX) begin
         r.val = FIX_MAX;
         r.ovf = 1'b1;
      end else if (v < SUM_FIX_MIN) begin
         r.val = FIX_MIN;
         r.ovf = 1'b1;
      end else begin
         r.val = fix_type'(v);
         r.ovf = 1'b0;
      end
      return r;
   endfunction

endpackage

[design/rk4s_req_if.sv]
interface rk4s_req_if;
   logic                 valid;
   logic                 ready;
   logic                 kind;
   rk4s_pkg::fix_type    init_x;
   rk4s_pkg::fix_type    init_y;
   rk4s_pkg::fix_type    init_z;

   modport source (output valid, kind, init_x, init_y, init_z, input ready);
   modport sink   (input valid, kind, init_x, init_y, init_z, output ready);
endinterface

[design/rk4s_rsp_if.sv]
interface rk4s_rsp_if;
   logic                  valid;
   logic                  ready;
   rk4s_pkg::fix_type     cur_x;
   rk4s_pkg::fix_type     cur_y;
   rk4s_pkg::fix_type     cur_z;
   rk4s_pkg::count_type   step_count;
   logic                  last;
   logic                  overflow;

   modport source (output valid, cur_x, cur_y, cur_z, step_count, last, overflow,
                   input ready);
   modport sink   (input valid, cur_x, cur_y, cur_z, step_count, last, overflow,
                   output ready);
endinterface

[design/rk4s_mul.sv]
module rk4s_mul (
   input  logic                 clock,
   input  rk4s_pkg::mul_type    mul_a,
   input  rk4s_pkg::mul_type    mul_b,
   output rk4s_pkg::prod_type   mul_p
);

   // Signed multiply with the product registered for the next cycle.
   rk4s_pkg::prod_type prod_ff;
   rk4s_pkg::prod_type prod_in;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_p = prod_ff;

endmodule

[design/rk4_two_equation_stepper.sv]
// Fixed-point fourth-order Runge-Kutta stepper for dy/dx = z*y + x and dz/dx = z*x + y,
// all values signed Q16.16. A load item (kind 0) sets x, y and z and clears the step
// count; a step item (kind 1) advances x by step_size with the classical four-stage
// update, saturating slopes, increments, stage arguments and the new x, y and z. Each
// item returns exactly one result with the new x, y, z, the step count (saturating at
// 65535), last (x at or above end_x) and overflow (some value in this step was clamped;
// always 0 for a load). The single 33x33 multiplier runs 24 products per step (16 for
// the stage slopes and their scaling by h, 8 for the rounded divisions by 3 and 6) in
// seven-slot stages of a small sequencer. req_chan.ready is high only while the block
// is idle. The result sits in an output register, so the next item is taken while a
// result waits; a finished item holds in its write-back state until the previous
// result has been taken. step_size and end_x are to be written through the csr port
// only while the block is idle; the block itself does not enforce this.
module rk4_two_equation_stepper (
   input  logic                              clock,
   input  logic                              reset,
   rk4s_req_if.sink                          req_chan,
   rk4s_rsp_if.source                        rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [rk4s_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rk4s_pkg::DATA_W-1:0]       csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_WRAP,
      ST_FINAL
   } state_type;

   // Seven slots per Runge-Kutta stage. The two slope products, one per equation,
   // come first, then their scaling by h, then the rounded divisions that feed
   // the final weighted sums. PREPY issues nothing; it forms the next stage
   // argument for y while the last h product drains.
   typedef enum logic [2:0] {
      SL_ZY,
      SL_ZX,
      SL_HFY,
      SL_HFZ,
      SL_PREPY,
      SL_DIVY,
      SL_DIVZ
   } slot_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_ZY,
      OP_ZX,
      OP_HFY,
      OP_HFZ,
      OP_DIVY,
      OP_DIVZ
   } op_type;

   // What the product register holds this cycle and which stage issued it.
   typedef struct packed {
      op_type               op;
      rk4s_pkg::stage_type  stage;
   } post_type;

   state_type               state_ff, state_in;
   slot_type                slot_ff, slot_in;
   rk4s_pkg::stage_type     stage_ff, stage_in;
   post_type                post_ff, post_in;
   logic                    kind_ff, kind_in;

   // Architectural state and configuration.
   rk4s_pkg::fix_type       pos_x_ff, pos_x_in;
   rk4s_pkg::fix_type       val_y_ff, val_y_in;
   rk4s_pkg::fix_type       val_z_ff, val_z_in;
   rk4s_pkg::count_type     steps_ff, steps_in;
   rk4s_pkg::step_type      step_size_ff, step_size_in;
   rk4s_pkg::fix_type       end_x_ff, end_x_in;

   // Working registers of one step.
   rk4s_pkg::fix_type       xm_ff, xm_in;
   rk4s_pkg::fix_type       xe_ff, xe_in;
   rk4s_pkg::fix_type       xa_ff, xa_in;
   rk4s_pkg::fix_type       ya_ff, ya_in;
   rk4s_pkg::fix_type       za_ff, za_in;
   rk4s_pkg::fix_type       fy_ff, fy_in;
   rk4s_pkg::fix_type       fz_ff, fz_in;
   rk4s_pkg::fix_type       ky_ff, ky_in;
   rk4s_pkg::fix_type       kz_ff, kz_in;
   logic [rk4s_pkg::DATA_W-1:0] ny_ff, ny_in;
   logic [rk4s_pkg::DATA_W-1:0] nz_ff, nz_in;
   logic                    negy_ff, negy_in;
   logic                    negz_ff, negz_in;
   rk4s_pkg::acc_type       accy_ff, accy_in;
   rk4s_pkg::acc_type       accz_ff, accz_in;
   logic                    ovf_ff, ovf_in;

   // Result register.
   logic                    rsp_valid_ff, rsp_valid_in;
   rk4s_pkg::fix_type       cur_x_ff, cur_x_in;
   rk4s_pkg::fix_type       cur_y_ff, cur_y_in;
   rk4s_pkg::fix_type       cur_z_ff, cur_z_in;
   rk4s_pkg::count_type     cur_count_ff, cur_count_in;
   logic                    cur_last_ff, cur_last_in;
   logic                    cur_ovf_ff, cur_ovf_in;

   // Shared multiplier.
   rk4s_pkg::mul_type       mul_a, mul_b;
   rk4s_pkg::prod_type      mul_p;

   op_type                  issue_op;
   logic                    req_take;
   logic                    rsp_free;

   // Combinational helpers.
   rk4s_pkg::sum_type       prod_ext;
   rk4s_pkg::sat_type       post_sat;
   logic                    post_ovf;
   rk4s_pkg::prod_type      div_shifted;
   rk4s_pkg::acc_type       div_term;
   rk4s_pkg::fix_type       prep_k;
   rk4s_pkg::fix_type       prep_base;
   logic [rk4s_pkg::DATA_W-1:0] prep_mag;
   logic [rk4s_pkg::DATA_W-1:0] prep_bias;
   logic [rk4s_pkg::DATA_W-1:0] prep_n;
   rk4s_pkg::sum_type       prep_sum;
   rk4s_pkg::sat_type       prep_sat;
   logic                    prep_ovf;
   rk4s_pkg::sat_type       init_xm;
   rk4s_pkg::sat_type       init_xe;
   rk4s_pkg::sat_type       fin_y;
   rk4s_pkg::sat_type       fin_z;

   rk4s_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   assign req_take = req_chan.valid && (state_ff == ST_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   // Operand selection for the shared multiplier.
   always_comb begin
      unique case (issue_op)
         OP_ZY: begin
            mul_a = rk4s_pkg::mul_type'(za_ff);
            mul_b = rk4s_pkg::mul_type'(ya_ff);
         end
         OP_ZX: begin
            mul_a = rk4s_pkg::mul_type'(za_ff);
            mul_b = rk4s_pkg::mul_type'(xa_ff);
         end
         OP_HFY: begin
            mul_a = rk4s_pkg::mul_type'({1'b0, step_size_ff});
            mul_b = rk4s_pkg::mul_type'(fy_ff);
         end
         OP_HFZ: begin
            mul_a = rk4s_pkg::mul_type'({1'b0, step_size_ff});
            mul_b = rk4s_pkg::mul_type'(fz_ff);
         end
         OP_DIVY: begin
            mul_a = rk4s_pkg::mul_type'(ny_ff);
            mul_b = rk4s_pkg::mul_type'(rk4s_pkg::RECIP3);
         end
         OP_DIVZ: begin
            mul_a = rk4s_pkg::mul_type'(nz_ff);
            mul_b = rk4s_pkg::mul_type'(rk4s_pkg::RECIP3);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Product post-processing. A slope product gets the rounding half, the
   // addend and one saturation in a single three-input sum; an h product is
   // rounded and saturated into a stage increment; a division product is
   // shifted down and added into the weighted sum with the saved sign.
   always_comb begin
      prod_ext = rk4s_pkg::sum_type'(mul_p);
      if ((post_ff.stage == rk4s_pkg::STG_1) || (post_ff.stage == rk4s_pkg::STG_4)) begin
         div_shifted = mul_p >>> rk4s_pkg::DIV6_SHIFT;
      end else begin
         div_shifted = mul_p >>> rk4s_pkg::DIV3_SHIFT;
      end
      div_term = rk4s_pkg::acc_type'(div_shifted[rk4s_pkg::DATA_W-1:0]);
      case (post_ff.op)
         OP_ZY: post_sat = rk4s_pkg::sat_fix((prod_ext
                              + (rk4s_pkg::sum_type'(xa_ff) <<< rk4s_pkg::FRAC_BITS)
                              + rk4s_pkg::ROUND_HALF) >>> rk4s_pkg::FRAC_BITS);
         OP_ZX: post_sat = rk4s_pkg::sat_fix((prod_ext
                              + (rk4s_pkg::sum_type'(ya_ff) <<< rk4s_pkg::FRAC_BITS)
                              + rk4s_pkg::ROUND_HALF) >>> rk4s_pkg::FRAC_BITS);
         default: post_sat = rk4s_pkg::sat_fix((prod_ext + rk4s_pkg::ROUND_HALF)
                              >>> rk4s_pkg::FRAC_BITS);
      endcase
      post_ovf = post_sat.ovf && (post_ff.op inside {OP_ZY, OP_ZX, OP_HFY, OP_HFZ});
   end

   // Stage argument and divisor operand from a fresh increment k. The half
   // step y + round(k/2) is formed as floor((2y + k + [k >= 0]) / 2), which
   // rounds ties away from zero; after stage 3 it is y + k. The division
   // operand is |k| + half the divisor, so the reciprocal product rounds to nearest.
   always_comb begin
      if (slot_ff == SL_PREPY) begin
         prep_k    = ky_ff;
         prep_base = val_y_ff;
      end else begin
         prep_k    = kz_ff;
         prep_base = val_z_ff;
      end
      if (stage_ff == rk4s_pkg::STG_3) begin
         prep_sum = (rk4s_pkg::sum_type'(prep_base) <<< 1)
                  + (rk4s_pkg::sum_type'(prep_k) <<< 1);
      end else begin
         prep_sum = (rk4s_pkg::sum_type'(prep_base) <<< 1)
                  + rk4s_pkg::sum_type'(prep_k)
                  + rk4s_pkg::sum_type'(!prep_k[rk4s_pkg::DATA_W-1]);
      end
      prep_sat = rk4s_pkg::sat_fix(prep_sum >>> 1);
      if ((stage_ff == rk4s_pkg::STG_1) || (stage_ff == rk4s_pkg::STG_4)) begin
         prep_bias = rk4s_pkg::DIV6_BIAS;
      end else begin
         prep_bias = rk4s_pkg::DIV3_BIAS;
      end
      prep_mag = prep_k;
      if (prep_k[rk4s_pkg::DATA_W-1]) begin
         prep_n = (~prep_mag) + prep_bias + rk4s_pkg::DATA_W'(1);
      end else begin
         prep_n = prep_mag + prep_bias;
      end
      // After the last stage there is no further argument to form.
      prep_ovf = prep_sat.ovf && (stage_ff != rk4s_pkg::STG_4);
   end

   // Midpoint and end abscissae of the step, and the final clamp of y and z.
   always_comb begin
      init_xm = rk4s_pkg::sat_fix(rk4s_pkg::sum_type'(pos_x_ff)
                + rk4s_pkg::sum_type'((rk4s_pkg::DATA_W'(step_size_ff)
                + rk4s_pkg::DATA_W'(1)) >> 1));
      init_xe = rk4s_pkg::sat_fix(rk4s_pkg::sum_type'(pos_x_ff)
                + rk4s_pkg::sum_type'(step_size_ff));
      fin_y   = rk4s_pkg::sat_fix(rk4s_pkg::sum_type'(accy_ff));
      fin_z   = rk4s_pkg::sat_fix(rk4s_pkg::sum_type'(accz_ff));
   end

   // Sequencer and register next values.
   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      stage_in      = stage_ff;
      kind_in       = kind_ff;
      pos_x_in      = pos_x_ff;
      val_y_in      = val_y_ff;
      val_z_in      = val_z_ff;
      steps_in      = steps_ff;
      step_size_in  = step_size_ff;
      end_x_in      = end_x_ff;
      xm_in         = xm_ff;
      xe_in         = xe_ff;
      xa_in         = xa_ff;
      ya_in         = ya_ff;
      za_in         = za_ff;
      fy_in         = fy_ff;
      fz_in         = fz_ff;
      ky_in         = ky_ff;
      kz_in         = kz_ff;
      ny_in         = ny_ff;
      nz_in         = nz_ff;
      negy_in       = negy_ff;
      negz_in       = negz_ff;
      accy_in       = accy_ff;
      accz_in       = accz_ff;
      ovf_in        = ovf_ff | post_ovf;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      cur_z_in      = cur_z_ff;
      cur_count_in  = cur_count_ff;
      cur_last_in   = cur_last_ff;
      cur_ovf_in    = cur_ovf_ff;
      issue_op      = OP_NONE;

      // Results of the product that was issued last cycle.
      case (post_ff.op)
         OP_ZY:   fy_in = post_sat.val;
         OP_ZX:   fz_in = post_sat.val;
         OP_HFY:  ky_in = post_sat.val;
         OP_HFZ:  kz_in = post_sat.val;
         OP_DIVY: accy_in = negy_ff ? (accy_ff - div_term) : (accy_ff + div_term);
         OP_DIVZ: accz_in = negz_ff ? (accz_ff - div_term) : (accz_ff + div_term);
         default: ;
      endcase

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               kind_in = req_chan.kind;
               if (req_chan.kind) begin
                  xm_in    = init_xm.val;
                  xe_in    = init_xe.val;
                  ovf_in   = init_xm.ovf | init_xe.ovf;
                  xa_in    = pos_x_ff;
                  ya_in    = val_y_ff;
                  za_in    = val_z_ff;
                  accy_in  = rk4s_pkg::acc_type'(val_y_ff);
                  accz_in  = rk4s_pkg::acc_type'(val_z_ff);
                  slot_in  = SL_ZY;
                  stage_in = rk4s_pkg::STG_1;
                  state_in = ST_RUN;
               end else begin
                  // A load goes straight to the write-back with the new values.
                  xe_in    = req_chan.init_x;
                  accy_in  = rk4s_pkg::acc_type'(req_chan.init_y);
                  accz_in  = rk4s_pkg::acc_type'(req_chan.init_z);
                  ovf_in   = 1'b0;
                  state_in = ST_FINAL;
               end
            end
         end
         ST_RUN: begin
            unique case (slot_ff)
               SL_ZY: begin
                  issue_op = OP_ZY;
                  slot_in  = SL_ZX;
               end
               SL_ZX: begin
                  issue_op = OP_ZX;
                  slot_in  = SL_HFY;
               end
               SL_HFY: begin
                  issue_op = OP_HFY;
                  slot_in  = SL_HFZ;
               end
               SL_HFZ: begin
                  issue_op = OP_HFZ;
                  slot_in  = SL_PREPY;
               end
               SL_PREPY: begin
                  ny_in   = prep_n;
                  negy_in = prep_k[rk4s_pkg::DATA_W-1];
                  if (stage_ff != rk4s_pkg::STG_4) begin
                     ya_in  = prep_sat.val;
                     ovf_in = ovf_ff | post_ovf | prep_ovf;
                  end
                  if (stage_ff == rk4s_pkg::STG_3) begin
                     xa_in = xe_ff;
                  end else begin
                     xa_in = xm_ff;
                  end
                  slot_in = SL_DIVY;
               end
               SL_DIVY: begin
                  issue_op = OP_DIVY;
                  nz_in    = prep_n;
                  negz_in  = prep_k[rk4s_pkg::DATA_W-1];
                  if (stage_ff != rk4s_pkg::STG_4) begin
                     za_in  = prep_sat.val;
                     ovf_in = ovf_ff | post_ovf | prep_ovf;
                  end
                  slot_in = SL_DIVZ;
               end
               SL_DIVZ: begin
                  issue_op = OP_DIVZ;
                  slot_in  = SL_ZY;
                  if (stage_ff == rk4s_pkg::STG_4) begin
                     state_in = ST_WRAP;
                  end else begin
                     stage_in = rk4s_pkg::STAGE_W'(stage_ff + 1'b1);
                  end
               end
               default: slot_in = SL_ZY;
            endcase
         end
         ST_WRAP: begin
            // The last division product is folded into the z sum this cycle.
            state_in = ST_FINAL;
         end
         ST_FINAL: begin
            if (rsp_free) begin
               pos_x_in = xe_ff;
               val_y_in = fin_y.val;
               val_z_in = fin_z.val;
               if (!kind_ff) begin
                  steps_in = '0;
               end else if (steps_ff != {rk4s_pkg::COUNT_W{1'b1}}) begin
                  steps_in = rk4s_pkg::COUNT_W'(steps_ff + 1'b1);
               end
               cur_x_in     = xe_ff;
               cur_y_in     = fin_y.val;
               cur_z_in     = fin_z.val;
               cur_count_in = steps_in;
               cur_last_in  = (xe_ff >= end_x_ff);
               cur_ovf_in   = ovf_ff | fin_y.ovf | fin_z.ovf;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      post_in.op    = issue_op;
      post_in.stage = stage_ff;

      if (csr_wr_en) begin
         unique case (rk4s_pkg::csr_index_type'(csr_index))
            rk4s_pkg::CSR_STEP_SIZE: step_size_in = csr_wdata[rk4s_pkg::STEP_W-1:0];
            rk4s_pkg::CSR_END_X:     end_x_in     = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= SL_ZY;
         stage_ff     <= rk4s_pkg::STG_1;
         post_ff      <= '{op: OP_NONE, stage: rk4s_pkg::STG_1};
         kind_ff      <= 1'b0;
         pos_x_ff     <= '0;
         val_y_ff     <= '0;
         val_z_ff     <= '0;
         steps_ff     <= '0;
         step_size_ff <= rk4s_pkg::STEP_SIZE_RESET;
         end_x_ff     <= rk4s_pkg::END_X_RESET;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         stage_ff     <= stage_in;
         post_ff      <= post_in;
         kind_ff      <= kind_in;
         pos_x_ff     <= pos_x_in;
         val_y_ff     <= val_y_in;
         val_z_ff     <= val_z_in;
         steps_ff     <= steps_in;
         step_size_ff <= step_size_in;
         end_x_ff     <= end_x_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      xm_ff        <= xm_in;
      xe_ff        <= xe_in;
      xa_ff        <= xa_in;
      ya_ff        <= ya_in;
      za_ff        <= za_in;
      fy_ff        <= fy_in;
      fz_ff        <= fz_in;
      ky_ff        <= ky_in;
      kz_ff        <= kz_in;
      ny_ff        <= ny_in;
      nz_ff        <= nz_in;
      negy_ff      <= negy_in;
      negz_ff      <= negz_in;
      accy_ff      <= accy_in;
      accz_ff      <= accz_in;
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      cur_z_ff     <= cur_z_in;
      cur_count_ff <= cur_count_in;
      cur_last_ff  <= cur_last_in;
      cur_ovf_ff   <= cur_ovf_in;
   end

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.cur_x      = cur_x_ff;
   assign rsp_chan.cur_y      = cur_y_ff;
   assign rsp_chan.cur_z      = cur_z_ff;
   assign rsp_chan.step_count = cur_count_ff;
   assign rsp_chan.last       = cur_last_ff;
   assign rsp_chan.overflow   = cur_ovf_ff;

`ifndef SYNTHESIS
   // A new result is only ever produced by the write-back state.
   a_rsp_from_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == ST_FINAL))
      else $error("result appeared outside write-back");

   // The last division product of a step must be in flight during the wrap cycle.
   a_wrap_drains_divz: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRAP) |-> ((post_ff.op == OP_DIVZ) && (post_ff.stage == rk4s_pkg::STG_4)))
      else $error("wrap cycle without the final z division");

   // A load never carries an overflow into its write-back.
   a_load_no_ovf: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FINAL) && !kind_ff) |-> !ovf_ff)
      else $error("load item flagged overflow");
`endif

endmodule
